// File: hw/rtl/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Shared types and constants of the running mean / variance / std dev unit.
// ----------------------------------------------------------------------------
package rmvs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int MEAN_W          = 32;
    localparam int SUM_W           = 64;
    localparam int VAR_W           = 48;
    localparam int SD_W            = 24;
    localparam int CNT_OUT_W       = 16;

    typedef enum logic [0:0] {
        ACT_APPEND  = 1'b0,
        ACT_RESTART = 1'b1
    } t_action;

    // command kinds handed from the front to the back
    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_FIRST   = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_FULL    = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_SETUP,
        ST_MUL,
        ST_ACC,
        ST_VAR,
        ST_DIV2,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

// File: hw/rtl/rmvs_front.sv
// ----------------------------------------------------------------------------
// rmvs_front
// Accepts input items, tracks the sample count and classifies each item into
// a command for the back end; holds a two-entry command queue.
// ----------------------------------------------------------------------------
module rmvs_front import rmvs_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_action,
    input  logic [15:0]            i_sample,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_ready,
    output t_cmd                   o_cmd,
    output logic signed [SAMPLE_BITS-1:0] o_cmd_sample,
    output logic [COUNT_BITS-1:0]  o_cmd_count
);

    localparam logic [COUNT_BITS-1:0] CountMax = '1;
    localparam int QW = 2 + SAMPLE_BITS + COUNT_BITS;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [QW-1:0]         r_q [2];
    logic [1:0]            r_fill;
    logic                  r_rd, r_wr;
    logic                  push, pop;
    t_cmd                  cls;
    logic signed [SAMPLE_BITS-1:0] smp;

    // widths below 16 bits keep the low bits, wider widths sign-extend the port
    assign smp = SAMPLE_BITS'($signed(i_sample));

    always_comb begin
        n_count = r_count;
        if (i_action == ACT_RESTART) begin
            cls = CMD_RESTART;
            n_count = '0;
        end else if (r_count == CountMax) begin
            cls = CMD_FULL;
        end else if (r_count == '0) begin
            cls = CMD_FIRST;
            n_count = r_count + 1'b1;
        end else begin
            cls = CMD_UPDATE;
            n_count = r_count + 1'b1;
        end
    end

    assign o_ready     = (r_fill != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign {o_cmd, o_cmd_sample, o_cmd_count} = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fill  <= '0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            if (push) begin
                r_count <= n_count;
                r_wr    <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= {cls, smp, n_count};
        end
    end

endmodule

// File: hw/rtl/rmvs_divider.sv
// ----------------------------------------------------------------------------
// rmvs_divider
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmvs_divider import rmvs_pkg::*; #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   sh;

    assign sh     = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign trial  = sh - {1'b0, r_den};
    assign o_quot = r_q;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            if (!trial[DEN_W]) begin
                r_rem <= trial;
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

// File: hw/rtl/rmvs_back.sv
// ----------------------------------------------------------------------------
// rmvs_back
// Carries out the commands: on updates, mean update by division, deviation product,
// sum update; variance division (two samples or more) and square root; holds the result.
// ----------------------------------------------------------------------------
module rmvs_back import rmvs_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  t_cmd                   i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_cmd_sample,
    input  logic [COUNT_BITS-1:0]  i_cmd_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [MEAN_W-1:0]      o_mean_value,
    output logic [VAR_W-1:0]       o_variance_value,
    output logic [SD_W-1:0]        o_std_dev_value,
    output logic [CNT_OUT_W-1:0]   o_samples_seen,
    output logic                   o_count_saturated
);

    localparam int XW = SAMPLE_BITS + 16;                       // sample in Q.16
    localparam int DW = ((XW > MEAN_W) ? XW : MEAN_W) + 2;      // deviation width
    localparam int HW = (DW + 1) / 2;                           // multiplier half
    localparam int PW = 4 * HW;                                 // product width
    localparam logic signed [DW-1:0] MeanMax = DW'(64'sh7FFF_FFFF);
    localparam logic signed [DW-1:0] MeanMin = -DW'(64'sh8000_0000);

    t_state r_state, n_state;

    logic signed [MEAN_W-1:0] r_mean;
    logic [SUM_W-1:0]         r_sum;
    logic [COUNT_BITS-1:0]    r_cnt;
    logic                     r_flag;
    logic signed [DW-1:0]     r_x, r_dold, r_dnew;
    logic [2*HW-1:0]          r_ma, r_mb;
    logic [PW-1:0]            r_prod;
    logic [1:0]               r_pidx;
    logic [VAR_W-1:0]         r_vsat;
    logic [VAR_W-1:0]         r_sval;
    logic [SD_W+2:0]          r_srem;
    logic [SD_W-1:0]          r_root;
    logic [4:0]               r_sstep;
    logic                     r_valid;
    logic [MEAN_W-1:0]        r_res_mean;
    logic [VAR_W-1:0]         r_res_var;
    logic [SD_W-1:0]          r_res_sd;
    logic [CNT_OUT_W-1:0]     r_res_cnt;
    logic                     r_res_sat;

    logic                     accept;
    logic                     var_low;
    logic                     sq_load;
    logic signed [DW-1:0]     x_in, d_in, d_now;
    logic [DW-1:0]            d_in_mag, dold_mag, dnow_mag;
    logic                     div_start, div_done;
    logic [SUM_W-1:0]         div_num, div_quot;
    logic [COUNT_BITS-1:0]    div_den;
    logic signed [DW-1:0]     step_s, new_mean;
    logic [HW-1:0]            ha, hb;
    logic [2*HW-1:0]          pp;
    logic [PW-1:0]            pp_sh;
    logic [SUM_W-1:0]         p_shr;
    logic [SUM_W:0]           padd;
    logic [VAR_W-1:0]         var_sat;
    logic [SD_W+2:0]          srem_sh, sq_trial;

    rmvs_divider #(.NUM_W(SUM_W), .DEN_W(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_valid;
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign var_low     = (r_cnt < COUNT_BITS'(2));

    assign x_in     = DW'($signed({i_cmd_sample, 16'b0}));
    assign d_in     = x_in - DW'(r_mean);
    assign d_in_mag = d_in[DW-1] ? DW'(-d_in) : DW'(d_in);
    assign d_now    = r_x - DW'(r_mean);
    assign dold_mag = r_dold[DW-1] ? DW'(-r_dold) : DW'(r_dold);
    assign dnow_mag = d_now[DW-1] ? DW'(-d_now) : DW'(d_now);

    // truncation toward zero: divide the magnitude, then restore the sign
    assign step_s   = r_dold[DW-1] ? -$signed(div_quot[DW-1:0])
                                   : $signed(div_quot[DW-1:0]);
    assign new_mean = DW'(r_mean) + step_s;

    assign ha = r_pidx[1] ? r_ma[2*HW-1:HW] : r_ma[HW-1:0];
    assign hb = r_pidx[0] ? r_mb[2*HW-1:HW] : r_mb[HW-1:0];
    assign pp = ha * hb;

    always_comb begin
        unique case (r_pidx)
            2'd0:    pp_sh = PW'(pp);
            2'd1:    pp_sh = PW'(pp) << HW;
            2'd2:    pp_sh = PW'(pp) << HW;
            default: pp_sh = PW'(pp) << (2 * HW);
        endcase
    end

    always_comb begin
        p_shr = SUM_W'(r_prod >> 16);
        if ((r_prod >> (SUM_W + 16)) != '0) p_shr = '1;
    end

    assign padd    = {1'b0, r_sum} + {1'b0, p_shr};
    assign var_sat = ((div_quot >> VAR_W) != '0) ? '1 : div_quot[VAR_W-1:0];
    assign sq_load = (r_state == ST_VAR && var_low) || (r_state == ST_DIV2 && div_done);

    assign srem_sh  = {r_srem[SD_W:0], r_sval[VAR_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = (i_cmd == CMD_UPDATE) ? ST_DIV1 : ST_VAR;
            end
            ST_DIV1:  if (div_done) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_MUL;
            ST_MUL:   if (r_pidx == 2'd3) n_state = ST_ACC;
            ST_ACC:   n_state = ST_VAR;
            ST_VAR:   n_state = var_low ? ST_SQRT : ST_DIV2;
            ST_DIV2:  if (div_done) n_state = ST_SQRT;
            ST_SQRT:  if (r_sstep == 5'd1) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // divider operand selection and start pulses
    always_comb begin
        div_start = 1'b0;
        div_num   = r_sum;
        div_den   = r_cnt - 1'b1;
        if (accept && i_cmd == CMD_UPDATE) begin
            div_start = 1'b1;
            div_num   = SUM_W'(d_in_mag);
            div_den   = i_cmd_count;
        end else if (r_state == ST_VAR && !var_low) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_mean  <= '0;
            r_sum   <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            if (accept) begin
                r_flag <= (i_cmd == CMD_FULL);
                unique case (i_cmd)
                    CMD_RESTART: begin
                        r_cnt  <= '0;
                        r_mean <= '0;
                        r_sum  <= '0;
                    end
                    CMD_FIRST: begin
                        r_cnt <= i_cmd_count;
                        r_sum <= '0;
                        if (x_in > MeanMax) r_mean <= MeanMax[MEAN_W-1:0];
                        else if (x_in < MeanMin) r_mean <= MeanMin[MEAN_W-1:0];
                        else r_mean <= x_in[MEAN_W-1:0];
                    end
                    CMD_UPDATE: r_cnt <= i_cmd_count;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_DIV1 && div_done) begin
                if (new_mean > MeanMax) r_mean <= MeanMax[MEAN_W-1:0];
                else if (new_mean < MeanMin) r_mean <= MeanMin[MEAN_W-1:0];
                else r_mean <= new_mean[MEAN_W-1:0];
            end
            if (r_state == ST_ACC) begin
                if (r_dold != '0 && r_dnew != '0 && (r_dold[DW-1] != r_dnew[DW-1]))
                    r_sum <= (r_sum > p_shr) ? r_sum - p_shr : '0;
                else
                    r_sum <= padd[SUM_W] ? '1 : padd[SUM_W-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= x_in;
            r_dold <= d_in;
        end
        if (r_state == ST_SETUP) begin
            r_dnew <= d_now;
            r_ma   <= (2*HW)'(dold_mag);
            r_mb   <= (2*HW)'(dnow_mag);
            r_prod <= '0;
            r_pidx <= 2'd0;
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_prod + pp_sh;
            r_pidx <= r_pidx + 1'b1;
        end
        if (sq_load) begin
            r_vsat  <= var_low ? '0 : var_sat;
            r_sval  <= var_low ? '0 : var_sat;
            r_srem  <= '0;
            r_root  <= '0;
            r_sstep <= 5'(SD_W);
        end
        if (r_state == ST_SQRT) begin
            r_sstep <= r_sstep - 1'b1;
            r_sval  <= r_sval << 2;
            if (srem_sh >= sq_trial) begin
                r_srem <= srem_sh - sq_trial;
                r_root <= {r_root[SD_W-2:0], 1'b1};
            end else begin
                r_srem <= srem_sh;
                r_root <= {r_root[SD_W-2:0], 1'b0};
            end
        end
        if (r_state == ST_OUT) begin
            r_res_mean <= r_mean;
            r_res_var  <= r_vsat;
            r_res_sd   <= r_root;
            r_res_cnt  <= CNT_OUT_W'(r_cnt);
            r_res_sat  <= r_flag;
        end
    end

    assign o_valid           = r_valid;
    assign o_mean_value      = r_res_mean;
    assign o_variance_value  = r_res_var;
    assign o_std_dev_value   = r_res_sd;
    assign o_samples_seen    = r_res_cnt;
    assign o_count_saturated = r_res_sat;

endmodule

// File: hw/rtl/running_mean_variance_stddev_unit.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stddev_unit
// Welford running mean, sample variance and standard deviation.
//
//   channel | direction | signals
//   input   | in        | i_valid / o_ready, i_action, i_sample
//   result  | out       | o_valid / i_ready, o_mean_value .. o_count_saturated
//
// an appended sample takes the back through the mean step division, the
// deviation product and sum update, the sum / (n-1) division, 24 root steps
// and the result load; both divisions use the shared 64-bit radix-2 divider
// restart/first samples go to root steps; full counts to the variance division
// the back takes its next command at the edge after its result is transferred
// two-entry command queue buffers items; reset clears counts and control state
// ----------------------------------------------------------------------------
module running_mean_variance_stddev_unit import rmvs_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [15:0]          i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MEAN_W-1:0]    o_mean_value,
    output logic [VAR_W-1:0]     o_variance_value,
    output logic [SD_W-1:0]      o_std_dev_value,
    output logic [CNT_OUT_W-1:0] o_samples_seen,
    output logic                 o_count_saturated
);

    logic                          cmd_valid, cmd_ready;
    t_cmd                          cmd;
    logic signed [SAMPLE_BITS-1:0] cmd_sample;
    logic [COUNT_BITS-1:0]         cmd_count;

    rmvs_front #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_sample     (i_sample),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd),
        .o_cmd_sample (cmd_sample),
        .o_cmd_count  (cmd_count)
    );

    rmvs_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .o_cmd_ready       (cmd_ready),
        .i_cmd             (cmd),
        .i_cmd_sample      (cmd_sample),
        .i_cmd_count       (cmd_count),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_mean_value      (o_mean_value),
        .o_variance_value  (o_variance_value),
        .o_std_dev_value   (o_std_dev_value),
        .o_samples_seen    (o_samples_seen),
        .o_count_saturated (o_count_saturated)
    );

endmodule

// File: hw/rtl/rmvs_checker.sv
// ----------------------------------------------------------------------------
// rmvs_checker
// Port-level checks of the statistics unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmvs_checker import rmvs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [VAR_W-1:0]     o_variance_value,
    input logic [CNT_OUT_W-1:0] o_samples_seen,
    input logic                 o_count_saturated,
    input logic [MEAN_W-1:0]    o_mean_value
);

    // fewer than two samples gives zero variance
    a_var_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_samples_seen < 16'd2 |-> o_variance_value == '0)
        else $error("variance nonzero below two samples");

    // a saturated item never reports an empty count
    a_sat_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_count_saturated |-> o_samples_seen != '0)
        else $error("saturation flag with empty count");

    // empty statistics report zero mean
    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_samples_seen == '0 |-> o_mean_value == '0)
        else $error("nonzero mean with no samples");

    // valid and the variance result hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_variance_value))
        else $error("result changed while stalled");

endmodule

bind running_mean_variance_stddev_unit rmvs_checker u_rmvs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_variance_value  (o_variance_value),
    .o_samples_seen    (o_samples_seen),
    .o_count_saturated (o_count_saturated),
    .o_mean_value      (o_mean_value)
);
